// ===== hdl/mfa_pkg.sv =====
package mfa_pkg;

  localparam int NODES = 128;
  localparam int NW = $clog2(NODES);
  localparam int AW = 2 * NW;
  localparam int CAP_W = 24;
  localparam int FLOW_W = CAP_W + 1;
  localparam int IN_CAP_W = 16;
  localparam int TOTAL_W = 31;
  localparam logic [TOTAL_W-1:0] INF_FLOW = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [CAP_W-1:0]  wdata;
    logic [AW-1:0]     raddr;
  } cap_port_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [FLOW_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } flow_port_t;

  typedef struct packed {
    logic          we;
    logic [NW-1:0] waddr;
    logic [NW-1:0] wdata;
    logic [NW-1:0] raddr;
  } node_port_t;

  typedef struct packed {
    logic              we;
    logic [NW-1:0]     waddr;
    logic [FLOW_W-1:0] wdata;
    logic [NW-1:0]     raddr;
  } bn_port_t;

endpackage

// ===== hdl/mfa_ram.sv =====
module mfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mfa_ctrl.sv =====
module mfa_ctrl import mfa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [NW-1:0]       node_a,
  input  logic [NW-1:0]       node_b,
  input  logic [IN_CAP_W-1:0] capacity,
  input  logic [NW-1:0]       node_count,
  input  logic [NW-1:0]       source_node,
  input  logic [NW-1:0]       sink_node,
  input  logic                out_free,
  output logic                res_vld,
  output logic [TOTAL_W-1:0]  res_data,
  output cap_port_t           cap_p,
  input  logic [CAP_W-1:0]    cap_rdata,
  output flow_port_t          flow_p,
  input  logic [FLOW_W-1:0]   flow_rdata,
  output node_port_t          par_p,
  input  logic [NW-1:0]       par_rdata,
  output bn_port_t            bn_p,
  input  logic [FLOW_W-1:0]   bn_rdata,
  output node_port_t          q_p,
  input  logic [NW-1:0]       q_rdata
);

  typedef enum logic [16:0] {
    S_CLR      = 17'h00001,
    S_IDLE     = 17'h00002,
    S_ADD_R1   = 17'h00004,
    S_ADD_W1   = 17'h00008,
    S_ADD_R2   = 17'h00010,
    S_ADD_W2   = 17'h00020,
    S_FCLR     = 17'h00040,
    S_BFS_INIT = 17'h00080,
    S_DQ_RD    = 17'h00100,
    S_DQ_WT    = 17'h00200,
    S_DQ_BN    = 17'h00400,
    S_SCAN     = 17'h00800,
    S_AUG_RDP  = 17'h01000,
    S_AUG_P    = 17'h02000,
    S_AUG_F    = 17'h04000,
    S_AUG_W2   = 17'h08000,
    S_FIN      = 17'h10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic [NW-1:0]       a_r, a_nxt, b_r, b_nxt, n_r, n_nxt, s_r, s_nxt, t_r, t_nxt;
  logic [IN_CAP_W-1:0] c_r, c_nxt;
  logic [NODES-1:0]    visited_r, visited_nxt;
  logic [NW:0]         head_r, head_nxt, tail_r, tail_nxt, iss_j_r, iss_j_nxt;
  logic [NW-1:0]       i_r, i_nxt, rd_j_r, rd_j_nxt, aj_r, aj_nxt, ai_r, ai_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [FLOW_W-1:0]   bn_i_r, bn_i_nxt, df_r, df_nxt, newf_r, newf_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;

  logic [CAP_W:0]      cap_sum;
  logic [CAP_W-1:0]    cap_sat;
  logic [FLOW_W:0]     resid;
  logic                resid_pos;
  logic [FLOW_W-1:0]   min_bn;
  logic [TOTAL_W:0]    total_sum;

  always_comb begin
    cap_sum   = {1'b0, cap_rdata} + {{(CAP_W + 1 - IN_CAP_W){1'b0}}, c_r};
    cap_sat   = cap_sum[CAP_W] ? {CAP_W{1'b1}} : cap_sum[CAP_W-1:0];
    resid     = {2'b00, cap_rdata} - {flow_rdata[FLOW_W-1], flow_rdata};
    resid_pos = !resid[FLOW_W] && (resid != '0);
    min_bn    = (bn_i_r < resid[FLOW_W-1:0]) ? bn_i_r : resid[FLOW_W-1:0];
    total_sum = {1'b0, total_r} + {{(TOTAL_W + 1 - FLOW_W){1'b0}}, df_r};
  end

  always_comb begin
    state_nxt   = state_r;
    sweep_nxt   = sweep_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    n_nxt       = n_r;
    s_nxt       = s_r;
    t_nxt       = t_r;
    visited_nxt = visited_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    iss_j_nxt   = iss_j_r;
    i_nxt       = i_r;
    rd_j_nxt    = rd_j_r;
    rd_vld_nxt  = rd_vld_r;
    aj_nxt      = aj_r;
    ai_nxt      = ai_r;
    bn_i_nxt    = bn_i_r;
    df_nxt      = df_r;
    newf_nxt    = newf_r;
    total_nxt   = total_r;
    in_ready    = 1'b0;
    res_vld     = 1'b0;
    res_data    = total_r;
    cap_p       = '0;
    flow_p      = '0;
    par_p       = '0;
    bn_p        = '0;
    q_p         = '0;

    case (state_r)
      S_CLR: begin
        cap_p.we    = 1'b1;
        cap_p.waddr = sweep_r;
        sweep_nxt   = sweep_r + 1'b1;
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          a_nxt = node_a;
          b_nxt = node_b;
          c_nxt = capacity;
          n_nxt = node_count;
          s_nxt = source_node;
          t_nxt = sink_node;
          sweep_nxt = '0;
          total_nxt = '0;
          case (op)
            OP_CLEAR: state_nxt = S_CLR;
            OP_ADD:   state_nxt = S_ADD_R1;
            OP_RUN:   state_nxt = (source_node == sink_node) ? S_FIN : S_FCLR;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_R1: begin
        cap_p.raddr = {a_r, b_r};
        state_nxt   = S_ADD_W1;
      end
      S_ADD_W1: begin
        cap_p.we    = 1'b1;
        cap_p.waddr = {a_r, b_r};
        cap_p.wdata = cap_sat;
        state_nxt   = S_ADD_R2;
      end
      S_ADD_R2: begin
        cap_p.raddr = {b_r, a_r};
        state_nxt   = S_ADD_W2;
      end
      S_ADD_W2: begin
        cap_p.we    = 1'b1;
        cap_p.waddr = {b_r, a_r};
        cap_p.wdata = cap_sat;
        state_nxt   = S_IDLE;
      end
      S_FCLR: begin
        flow_p.we    = 1'b1;
        flow_p.waddr = sweep_r;
        sweep_nxt    = sweep_r + 1'b1;
        if (sweep_r == {AW{1'b1}}) begin
          state_nxt = S_BFS_INIT;
        end
      end
      S_BFS_INIT: begin
        visited_nxt       = '0;
        visited_nxt[s_r]  = 1'b1;
        par_p.we          = 1'b1;
        par_p.waddr       = s_r;
        par_p.wdata       = s_r;
        q_p.we            = 1'b1;
        q_p.waddr         = '0;
        q_p.wdata         = s_r;
        head_nxt          = '0;
        tail_nxt          = (NW + 1)'(1);
        state_nxt         = S_DQ_RD;
      end
      S_DQ_RD: begin
        if (head_r < tail_r) begin
          q_p.raddr = head_r[NW-1:0];
          head_nxt  = head_r + 1'b1;
          state_nxt = S_DQ_WT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DQ_WT: begin
        i_nxt      = q_rdata;
        bn_p.raddr = q_rdata;
        state_nxt  = S_DQ_BN;
      end
      S_DQ_BN: begin
        bn_i_nxt   = (i_r == s_r) ? {FLOW_W{1'b1}} : bn_rdata;
        iss_j_nxt  = (NW + 1)'(1);
        rd_vld_nxt = 1'b0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (rd_vld_r && !visited_r[rd_j_r] && resid_pos) begin
          visited_nxt[rd_j_r] = 1'b1;
          par_p.we    = 1'b1;
          par_p.waddr = rd_j_r;
          par_p.wdata = i_r;
          bn_p.we     = 1'b1;
          bn_p.waddr  = rd_j_r;
          bn_p.wdata  = min_bn;
          if (tail_r < (NW + 1)'(NODES)) begin
            q_p.we    = 1'b1;
            q_p.waddr = tail_r[NW-1:0];
            q_p.wdata = rd_j_r;
            tail_nxt  = tail_r + 1'b1;
          end
        end
        if (rd_vld_r && !visited_r[rd_j_r] && resid_pos && rd_j_r == t_r) begin
          df_nxt     = min_bn;
          aj_nxt     = t_r;
          rd_vld_nxt = 1'b0;
          state_nxt  = S_AUG_RDP;
        end else if (iss_j_r <= {1'b0, n_r}) begin
          cap_p.raddr  = {i_r, iss_j_r[NW-1:0]};
          flow_p.raddr = {i_r, iss_j_r[NW-1:0]};
          rd_vld_nxt   = 1'b1;
          rd_j_nxt     = iss_j_r[NW-1:0];
          iss_j_nxt    = iss_j_r + 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
          if (!rd_vld_r) begin
            state_nxt = S_DQ_RD;
          end
        end
      end
      S_AUG_RDP: begin
        par_p.raddr = aj_r;
        state_nxt   = S_AUG_P;
      end
      S_AUG_P: begin
        ai_nxt = par_rdata;
        if (par_rdata == aj_r) begin
          total_nxt = total_sum[TOTAL_W] ? INF_FLOW : total_sum[TOTAL_W-1:0];
          state_nxt = S_BFS_INIT;
        end else begin
          flow_p.raddr = {par_rdata, aj_r};
          state_nxt    = S_AUG_F;
        end
      end
      S_AUG_F: begin
        newf_nxt     = flow_rdata + df_r;
        flow_p.we    = 1'b1;
        flow_p.waddr = {ai_r, aj_r};
        flow_p.wdata = flow_rdata + df_r;
        state_nxt    = S_AUG_W2;
      end
      S_AUG_W2: begin
        flow_p.we    = 1'b1;
        flow_p.waddr = {aj_r, ai_r};
        flow_p.wdata = -newf_r;
        aj_nxt       = ai_r;
        state_nxt    = S_AUG_RDP;
      end
      S_FIN: begin
        if (out_free) begin
          res_vld   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      sweep_r   <= '0;
      visited_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      iss_j_r   <= '0;
      rd_vld_r  <= 1'b0;
      total_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      visited_r <= visited_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      iss_j_r   <= iss_j_nxt;
      rd_vld_r  <= rd_vld_nxt;
      total_r   <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    n_r    <= n_nxt;
    s_r    <= s_nxt;
    t_r    <= t_nxt;
    i_r    <= i_nxt;
    rd_j_r <= rd_j_nxt;
    aj_r   <= aj_nxt;
    ai_r   <= ai_nxt;
    bn_i_r <= bn_i_nxt;
    df_r   <= df_nxt;
    newf_r <= newf_nxt;
  end

endmodule

// ===== hdl/max_flow_bfs_augment.sv =====
// Channel  Direction  Handshake             Payload
// in       slave      in_tvalid/in_tready   tuser op, tdata edge and run fields
// out      master     out_tvalid/out_tready tdata total_flow
//
// A clear item sweeps the capacity memory, an add item updates both edge directions,
// and a run item clears the flow memory, then per search dequeues nodes, scans their
// neighbours and walks the augmenting path; the capacity and flow memories are read
// one entry per cycle in the scan. After reset a pass clears the capacity memory
// with in_tready low. One result register holds a finished result; the block takes
// new items while it waits, and a run that ends waits for it.
module max_flow_bfs_augment import mfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // node_a[6:0], node_b[13:7], capacity[29:14], node_count[36:30],
  // source_node[43:37], sink_node[50:44], zero fill[55:51]
  input  logic [55:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // total_flow[30:0], zero fill[31]
  output logic [31:0] out_tdata
);

  cap_port_t          cap_p;
  flow_port_t         flow_p;
  node_port_t         par_p;
  node_port_t         q_p;
  bn_port_t           bn_p;
  logic [CAP_W-1:0]   cap_rdata;
  logic [FLOW_W-1:0]  flow_rdata;
  logic [NW-1:0]      par_rdata;
  logic [NW-1:0]      q_rdata;
  logic [FLOW_W-1:0]  bn_rdata;
  logic               res_vld;
  logic [TOTAL_W-1:0] res_data;
  logic               out_free;
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_data_r;

  assign out_free = !out_valid_r || out_tready;

  mfa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser),
    .node_a      (in_tdata[6:0]),
    .node_b      (in_tdata[13:7]),
    .capacity    (in_tdata[29:14]),
    .node_count  (in_tdata[36:30]),
    .source_node (in_tdata[43:37]),
    .sink_node   (in_tdata[50:44]),
    .out_free    (out_free),
    .res_vld     (res_vld),
    .res_data    (res_data),
    .cap_p       (cap_p),
    .cap_rdata   (cap_rdata),
    .flow_p      (flow_p),
    .flow_rdata  (flow_rdata),
    .par_p       (par_p),
    .par_rdata   (par_rdata),
    .bn_p        (bn_p),
    .bn_rdata    (bn_rdata),
    .q_p         (q_p),
    .q_rdata     (q_rdata)
  );

  mfa_ram #(.WIDTH(CAP_W), .DEPTH(NODES * NODES)) u_cap_ram (
    .clk   (clk),
    .we    (cap_p.we),
    .waddr (cap_p.waddr),
    .wdata (cap_p.wdata),
    .raddr (cap_p.raddr),
    .rdata (cap_rdata)
  );

  mfa_ram #(.WIDTH(FLOW_W), .DEPTH(NODES * NODES)) u_flow_ram (
    .clk   (clk),
    .we    (flow_p.we),
    .waddr (flow_p.waddr),
    .wdata (flow_p.wdata),
    .raddr (flow_p.raddr),
    .rdata (flow_rdata)
  );

  mfa_ram #(.WIDTH(NW), .DEPTH(NODES)) u_par_ram (
    .clk   (clk),
    .we    (par_p.we),
    .waddr (par_p.waddr),
    .wdata (par_p.wdata),
    .raddr (par_p.raddr),
    .rdata (par_rdata)
  );

  mfa_ram #(.WIDTH(FLOW_W), .DEPTH(NODES)) u_bn_ram (
    .clk   (clk),
    .we    (bn_p.we),
    .waddr (bn_p.waddr),
    .wdata (bn_p.wdata),
    .raddr (bn_p.raddr),
    .rdata (bn_rdata)
  );

  mfa_ram #(.WIDTH(NW), .DEPTH(NODES)) u_q_ram (
    .clk   (clk),
    .we    (q_p.we),
    .waddr (q_p.waddr),
    .wdata (q_p.wdata),
    .raddr (q_p.raddr),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_vld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (!out_valid_r || out_tready))
    else $error("result produced while the output register is occupied");

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !res_vld)
    else $error("result produced while the block accepts items");

  a_res_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> out_tvalid && out_tdata[TOTAL_W-1:0] == $past(res_data))
    else $error("result not loaded into the output register");

endmodule

// ===== dv/tb_max_flow_bfs_augment.sv =====
`timescale 1ns / 1ps

module tb_max_flow_bfs_augment;
  import mfa_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // node_a[6:0], node_b[13:7], capacity[29:14], node_count[36:30],
  // source_node[43:37], sink_node[50:44], zero fill[55:51]
  logic [55:0] in_tdata = '0;
  // op[1:0]
  logic [1:0]  in_tuser = OP_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // total_flow[30:0], zero fill[31]
  logic [31:0] out_tdata;

  max_flow_bfs_augment dut (.*);

  always #10 clk = ~clk;

  logic [CAP_W-1:0] cap_mem [NODES][NODES];
  longint           flow_mem [NODES][NODES];
  bit               seen [NODES];
  int               parent [NODES];
  longint           limit_flow [NODES];
  int               bfs_queue [NODES];

  logic [TOTAL_W-1:0] flow_expected [$];
  int errors = 0;
  int n_runs = 0;
  int n_adds = 0;
  int n_results = 0;
  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;

  function automatic longint find_path(int s, int t, int n);
    int head;
    int tail;
    int i;
    longint r;
    head = 0;
    tail = 0;
    for (int k = 0; k < NODES; k++) begin
      seen[k] = 1'b0;
      parent[k] = 0;
      limit_flow[k] = 0;
    end
    seen[s] = 1'b1;
    parent[s] = s;
    limit_flow[s] = INF_FLOW;
    bfs_queue[tail++] = s;
    while (head < tail) begin
      i = bfs_queue[head++];
      for (int j = 1; j <= n; j++) begin
        r = longint'(cap_mem[i][j]) - flow_mem[i][j];
        if (!seen[j] && r > 0) begin
          seen[j] = 1'b1;
          parent[j] = i;
          limit_flow[j] = (limit_flow[i] < r) ? limit_flow[i] : r;
          if (tail < NODES) bfs_queue[tail++] = j;
          if (j == t) return limit_flow[t];
        end
      end
    end
    return limit_flow[t];
  endfunction

  function automatic logic [TOTAL_W-1:0] max_flow(int s, int t, int n);
    longint total;
    longint df;
    int i;
    int j;
    total = 0;
    if (s == t) return '0;
    if (n > NODES - 1) n = NODES - 1;
    for (int a = 0; a < NODES; a++)
      for (int b = 0; b < NODES; b++) flow_mem[a][b] = 0;
    df = find_path(s, t, n);
    while (df > 0) begin
      j = t;
      i = parent[t];
      while (i != j) begin
        flow_mem[i][j] += df;
        flow_mem[j][i] = -flow_mem[i][j];
        j = i;
        i = parent[j];
      end
      total += df;
      df = find_path(s, t, n);
    end
    if (total > INF_FLOW) total = INF_FLOW;
    return total[TOTAL_W-1:0];
  endfunction

  function automatic void add_capacity(int a, int b, int c);
    longint v;
    v = longint'(cap_mem[a][b]) + c;
    if (v > (longint'(1) << CAP_W) - 1) v = (longint'(1) << CAP_W) - 1;
    cap_mem[a][b] = v[CAP_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(op_t op, int a, int b, int c, int n, int s, int t);
    int gap;
    logic [6:0]  a7;
    logic [6:0]  b7;
    logic [15:0] c16;
    logic [6:0]  n7;
    logic [6:0]  s7;
    logic [6:0]  t7;
    a7 = a[6:0];
    b7 = b[6:0];
    c16 = c[15:0];
    n7 = n[6:0];
    s7 = s[6:0];
    t7 = t[6:0];
    gap = quiet_send ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {5'b0, t7, s7, n7, c16, b7, a7};
    do @(posedge clk); while (!in_tready);
    case (op)
      OP_CLEAR: begin
        for (int x = 0; x < NODES; x++)
          for (int y = 0; y < NODES; y++) cap_mem[x][y] = '0;
      end
      OP_ADD: begin
        add_capacity(int'(a7), int'(b7), int'(c16));
        add_capacity(int'(b7), int'(a7), int'(c16));
        n_adds++;
      end
      OP_RUN: begin
        flow_expected.push_back(max_flow(int'(s7), int'(t7), int'(n7)));
        n_runs++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (flow_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (quiet_recv) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) < 75);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (flow_expected.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $time, out_tdata);
        errors++;
      end else begin
        logic [TOTAL_W-1:0] e;
        e = flow_expected.pop_front();
        if (out_tdata !== {1'b0, e}) begin
          $display("%0t: total_flow mismatch, expected %0d, actual %0d",
                   $time, e, out_tdata);
          errors++;
        end
      end
    end
  end

  task automatic test_special_cases();
    quiet_send = 1'b1;
    send_item(OP_RUN, 0, 0, 0, 4, 1, 2);
    send_item(OP_ADD, 1, 2, 16'hFFFF, 0, 0, 0);
    send_item(OP_ADD, 2, 3, 0, 0, 0, 0);
    send_item(OP_ADD, 2, 3, 16'h1234, 0, 0, 0);
    send_item(OP_ADD, 1, 1, 16'hFFFF, 0, 0, 0);
    send_item(OP_ADD, 127, 127, 16'hFFFF, 0, 0, 0);
    send_item(OP_ADD, 0, 127, 16'h8000, 0, 0, 0);
    send_item(OP_NONE, 7'h7F, 7'h7F, 16'hFFFF, 7'h7F, 7'h7F, 7'h7F);
    send_item(OP_RUN, 0, 0, 0, 3, 1, 3);
    send_item(OP_RUN, 0, 0, 0, 3, 2, 2);
    send_item(OP_RUN, 0, 0, 0, 0, 1, 3);
    send_item(OP_RUN, 0, 0, 0, 2, 1, 3);
    send_item(OP_RUN, 0, 0, 0, 127, 0, 127);
    send_item(OP_RUN, 0, 0, 0, 127, 127, 1);
    send_item(OP_RUN, 7'h7F, 7'h7F, 16'hFFFF, 7'h7F, 3, 1);
    quiet_send = 1'b0;
    wait_drained();
  endtask

  task automatic test_accumulate();
    for (int k = 0; k < 4; k++) send_item(OP_ADD, 5, 6, 16'hFFFF, 0, 0, 0);
    send_item(OP_ADD, 6, 7, 16'hFFFF, 0, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 7, 5, 6);
    send_item(OP_RUN, 0, 0, 0, 7, 5, 7);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(OP_RUN, 0, 0, 0, 7, 5, 6);
    wait_drained();
  endtask

  task automatic test_random_graphs();
    int edges;
    int sz;
    for (int g = 0; g < 10; g++) begin
      quiet_send = (g % 4 == 1);
      quiet_recv = (g % 4 == 2);
      if (g % 4 == 0) send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom);
      sz = $urandom_range(3, 9);
      edges = $urandom_range(3, 7);
      for (int e = 0; e < edges; e++)
        send_item(OP_ADD, $urandom_range(1, sz), $urandom_range(1, sz),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50),
                  $urandom, $urandom, $urandom);
      if ($urandom_range(0, 2) == 0)
        send_item(op_t'($urandom_range(0, 3) == 0 ? OP_NONE : OP_ADD), $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom);
      send_item(OP_RUN, $urandom, $urandom, $urandom, sz, $urandom_range(0, sz),
                $urandom_range(1, sz + 1));
      send_item(OP_RUN, $urandom, $urandom, $urandom,
                ($urandom_range(0, 3) == 0) ? $urandom : sz,
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, sz),
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, sz));
      if (g == 6) wait_drained();
    end
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
    send_item(OP_RUN, 0, 0, 0, 127, 1, 2);
    wait_drained();
  endtask

  initial begin
    for (int x = 0; x < NODES; x++)
      for (int y = 0; y < NODES; y++) cap_mem[x][y] = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_accumulate();
    test_random_graphs();
    $display("Covered %0d add items and %0d runs with %0d results checked,", n_adds,
             n_runs, n_results);
    $display("including repeated adds, self loops, equal endpoints and stalls.");
    if (errors == 0 && flow_expected.size() == 0) begin
      $display("max_flow_bfs_augment regression: pass");
    end else begin
      $display("max_flow_bfs_augment regression: fail");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("max_flow_bfs_augment regression: fail");
    $finish;
  end

endmodule
